// ----- hdl/rnsu_pkg.sv -----
// Shared types, sizes and arithmetic helpers of the rate neuron state update core.
// No dependencies; rnsu_cfg, the core and the testbench import this package.
`default_nettype none

package rnsu_pkg;

    localparam int unsigned NEURONS  = 64;
    localparam int unsigned IDX_W    = $clog2(NEURONS);
    localparam int unsigned WADDR_W  = $clog2(NEURONS * NEURONS);
    localparam int unsigned CNT_W    = $clog2(NEURONS + 2);
    localparam int unsigned NEURON_W = 6;
    localparam int unsigned ACT_W    = 17;
    localparam int unsigned Q_W      = 32;
    localparam int unsigned SUM_W    = ACT_W + IDX_W;
    localparam int unsigned ACC_W    = 50 + IDX_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MA_W     = 35;
    localparam int unsigned MB_W     = 32;
    localparam int unsigned PROD_W   = MA_W + MB_W;
    localparam int unsigned PSH_W    = PROD_W - 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INHIBITION_GAIN   = 3'd0,
        REG_NOISE_GAIN        = 3'd1,
        REG_STEP_OVER_TAU     = 3'd2,
        REG_STEP_OVER_TAU_ADP = 3'd3,
        REG_INVERSE_TEMP      = 3'd4,
        REG_THRESHOLD         = 3'd5,
        REG_INV_ACTIVE_COUNT  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [30:0]        inhibition_gain;
        logic [30:0]        noise_gain;
        logic [16:0]        step_over_tau;
        logic [16:0]        step_over_tau_adapt;
        logic [30:0]        inverse_temperature;
        logic signed [31:0] threshold;
        logic [16:0]        inverse_active_count;
    } cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0]   act;
        logic signed [31:0] pot;
        logic signed [31:0] adapt;
    } nstate_t;

    localparam int unsigned NST_W = $bits(nstate_t);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [WADDR_W-1:0] weight_addr(input logic [IDX_W-1:0] row,
                                                       input logic [IDX_W-1:0] col);
        return WADDR_W'(32'(row) * NEURONS + 32'(col));
    endfunction

    // Piecewise linear sigmoid in Q1.16, symmetric around one half.
    function automatic logic [ACT_W-1:0] sigmoid(input logic signed [PSH_W-1:0] z);
        logic signed [PSH_W:0] zz;
        logic [PSH_W:0]        a;
        logic [ACT_W-1:0]      y;
        zz = (PSH_W+1)'(z);
        a  = zz[PSH_W] ? unsigned'(-zz) : unsigned'(zz);
        if (a >= (PSH_W+1)'(327680)) begin
            y = 17'd65536;
        end else if (a >= (PSH_W+1)'(155648)) begin
            y = 17'(a >> 5) + 17'd55296;
        end else if (a >= (PSH_W+1)'(65536)) begin
            y = 17'(a >> 3) + 17'd40960;
        end else begin
            y = 17'(a >> 2) + 17'd32768;
        end
        return zz[PSH_W] ? 17'd65536 - y : y;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rnsu_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module rnsu_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/rnsu_cfg.sv -----
// Configuration register bank of the rate neuron state update core.
// Depends on rnsu_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module rnsu_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wen,
    input  wire logic [rnsu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_wdata,
    output rnsu_pkg::cfg_t                          cfg
);
    import rnsu_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inhibition_gain      <= '0;
            cfg_reg.noise_gain           <= '0;
            cfg_reg.step_over_tau        <= 17'd6554;
            cfg_reg.step_over_tau_adapt  <= 17'd655;
            cfg_reg.inverse_temperature  <= 31'd65536;
            cfg_reg.threshold            <= '0;
            cfg_reg.inverse_active_count <= 17'd1024;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_INHIBITION_GAIN:   cfg_reg.inhibition_gain      <= cfg_wdata[30:0];
                REG_NOISE_GAIN:        cfg_reg.noise_gain           <= cfg_wdata[30:0];
                REG_STEP_OVER_TAU:     cfg_reg.step_over_tau        <= cfg_wdata[16:0];
                REG_STEP_OVER_TAU_ADP: cfg_reg.step_over_tau_adapt  <= cfg_wdata[16:0];
                REG_INVERSE_TEMP:      cfg_reg.inverse_temperature  <= cfg_wdata[30:0];
                REG_THRESHOLD:         cfg_reg.threshold            <= signed'(cfg_wdata);
                REG_INV_ACTIVE_COUNT:  cfg_reg.inverse_active_count <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/rate_neuron_state_update_core.sv -----
// Rate neuron state update core: weight load and asynchronous neuron update.
// A load beat goes straight to the weight memory and s_ready stays high. An update beat runs
// the single multiply-accumulate pass over the weight row, one weight and activity a cycle,
// then ST_RDI to ST_WB; the next beat is taken only after the result is written back.
// Reset clears control state, restores the register defaults and marks all neuron
// state invalid (reads as zero); the weight memory is not cleared.
`default_nettype none

module rate_neuron_state_update_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input channel.
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_mode,
    input  wire logic [rnsu_pkg::NEURON_W-1:0]      s_neuron,
    input  wire logic [rnsu_pkg::NEURON_W-1:0]      s_source,
    input  wire logic signed [31:0]                 s_weight_value,
    input  wire logic signed [31:0]                 s_ext_field,
    input  wire logic signed [31:0]                 s_back_field,
    input  wire logic [15:0]                        s_noise_sample,
    // Result channel.
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [rnsu_pkg::NEURON_W-1:0]           m_updated_neuron,
    output logic [rnsu_pkg::ACT_W-1:0]              m_activity,
    output logic signed [31:0]                      m_input_field,
    output logic signed [31:0]                      m_potential,
    // Configuration write port.
    input  wire logic                               cfg_wen,
    input  wire logic [rnsu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_wdata
);
    import rnsu_pkg::*;

    // The sequencer walks one update through the shared multiplier, one product per
    // state after the accumulate pass.
    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_MAC   = 13'b0000000000010,
        ST_RDI   = 13'b0000000000100,
        ST_MEAN  = 13'b0000000001000,
        ST_MSQ   = 13'b0000000010000,
        ST_INH   = 13'b0000000100000,
        ST_NZ    = 13'b0000001000000,
        ST_FIELD = 13'b0000010000000,
        ST_POT   = 13'b0000100000000,
        ST_POTW  = 13'b0001000000000,
        ST_ADAPT = 13'b0010000000000,
        ST_SIG   = 13'b0100000000000,
        ST_WB    = 13'b1000000000000
    } state_t;

    cfg_t cfg;

    rnsu_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    state_t state_reg, state_next;

    logic [NEURON_W-1:0]      i_reg;
    logic signed [31:0]       ext_reg, back_reg;
    logic [15:0]              noise_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     rd_v_reg, mac_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       r_reg, x_reg, h_reg;
    logic [ACT_W-1:0]         sold_reg, s_reg;
    logic signed [47:0]       inh_reg;
    logic [NEURONS-1:0]       vld_reg;
    logic                     vld_rd_reg;

    logic                     m_valid_reg;
    logic [NEURON_W-1:0]      m_neuron_reg;
    logic [ACT_W-1:0]         m_act_reg;
    logic signed [31:0]       m_field_reg, m_pot_reg;

    logic                     accept;
    logic                     load_ok, upd_ok;
    logic                     issue;
    logic                     wb_go;

    // Weight memory: one row per target neuron, read along the row during the pass.
    logic                     w_wr_en;
    logic [WADDR_W-1:0]       w_wr_addr, w_rd_addr;
    logic [31:0]              w_rd_data;

    // Neuron state memory: activity, potential and adaptation in one word.
    logic [IDX_W-1:0]         n_rd_addr;
    logic [NST_W-1:0]         n_rd_raw;
    nstate_t                  n_rd, n_wr;
    logic [ACT_W-1:0]         act_rd;

    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;
    logic signed [PSH_W-1:0]  psh;
    logic signed [ACC_W-17:0] acc_s;
    logic signed [31:0]       msq;
    logic signed [17:0]       noise_term;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign load_ok = accept && !s_mode && (32'(s_neuron) < NEURONS)
                     && (32'(s_source) < NEURONS);
    assign upd_ok  = accept && s_mode && (32'(s_neuron) < NEURONS);
    assign issue   = (state_reg == ST_MAC) && (32'(cnt_reg) < NEURONS);
    assign wb_go   = (state_reg == ST_WB) && (!m_valid_reg || m_ready);

    assign w_wr_en   = load_ok;
    assign w_wr_addr = weight_addr(IDX_W'(s_neuron), IDX_W'(s_source));
    assign w_rd_addr = weight_addr(IDX_W'(i_reg), cnt_reg[IDX_W-1:0]);

    rnsu_ram #(
        .DEPTH (NEURONS * NEURONS),
        .WIDTH (32)
    ) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (w_wr_en),
        .wr_addr (w_wr_addr),
        .wr_data (s_weight_value),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    assign n_rd_addr = (state_reg == ST_MAC) ? cnt_reg[IDX_W-1:0] : IDX_W'(i_reg);
    assign n_wr.act   = s_reg;
    assign n_wr.pot   = r_reg;
    assign n_wr.adapt = x_reg;

    rnsu_ram #(
        .DEPTH (NEURONS),
        .WIDTH (NST_W)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wb_go),
        .wr_addr (IDX_W'(i_reg)),
        .wr_data (n_wr),
        .rd_addr (n_rd_addr),
        .rd_data (n_rd_raw)
    );

    // Entries that were never written since reset read as zero.
    assign n_rd   = vld_rd_reg ? nstate_t'(n_rd_raw) : '0;
    assign act_rd = n_rd.act;

    // The product register shifted back to Q16.16, rounding toward minus infinity.
    assign psh        = signed'(prod_reg[PROD_W-1:16]);
    assign acc_s      = signed'(acc_reg[ACC_W-1:16]);
    assign msq        = sat32(64'(psh));
    assign noise_term = signed'({1'b0, noise_reg, 1'b0}) - 18'sd65536;

    // Operand selection for the shared multiplier.
    always_comb begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_MAC: begin
                ma = MA_W'(signed'(w_rd_data));
                mb = signed'(MB_W'(act_rd));
            end
            ST_MEAN: begin
                ma = signed'(MA_W'(sum_reg));
                mb = signed'(MB_W'(cfg.inverse_active_count));
            end
            ST_MSQ: begin
                ma = MA_W'(psh);
                mb = MB_W'(psh);
            end
            ST_INH: begin
                ma = MA_W'(msq);
                mb = signed'(MB_W'(cfg.inhibition_gain));
            end
            ST_NZ: begin
                ma = MA_W'(noise_term);
                mb = signed'(MB_W'(cfg.noise_gain));
            end
            ST_POT: begin
                ma = MA_W'(h_reg) - MA_W'(r_reg) - MA_W'(x_reg);
                mb = signed'(MB_W'(cfg.step_over_tau));
            end
            ST_POTW: begin
                ma = signed'(MA_W'(sold_reg)) - MA_W'(x_reg);
                mb = signed'(MB_W'(cfg.step_over_tau_adapt));
            end
            ST_ADAPT: begin
                // The new potential was written back to r_reg in the previous state.
                ma = MA_W'(r_reg) - MA_W'(cfg.threshold);
                mb = signed'(MB_W'(cfg.inverse_temperature));
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (upd_ok) state_next = ST_MAC;
            ST_MAC:   if (32'(cnt_reg) == NEURONS + 1) state_next = ST_RDI;
            ST_RDI:   state_next = ST_MEAN;
            ST_MEAN:  state_next = ST_MSQ;
            ST_MSQ:   state_next = ST_INH;
            ST_INH:   state_next = ST_NZ;
            ST_NZ:    state_next = ST_FIELD;
            ST_FIELD: state_next = ST_POT;
            ST_POT:   state_next = ST_POTW;
            ST_POTW:  state_next = ST_ADAPT;
            ST_ADAPT: state_next = ST_SIG;
            ST_SIG:   state_next = ST_WB;
            ST_WB:    if (wb_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_v_reg    <= 1'b0;
            mac_v_reg   <= 1'b0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
            mac_v_reg <= rd_v_reg;
            if (upd_ok) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_MAC) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (wb_go) begin
                vld_reg[IDX_W'(i_reg)] <= 1'b1;
                m_valid_reg            <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        vld_rd_reg <= vld_reg[n_rd_addr];
        if (upd_ok) begin
            i_reg     <= s_neuron;
            ext_reg   <= s_ext_field;
            back_reg  <= s_back_field;
            noise_reg <= s_noise_sample;
            acc_reg   <= '0;
            sum_reg   <= '0;
        end
        if (state_reg == ST_MAC) begin
            if (rd_v_reg) begin
                prod_reg <= ma * mb;
                sum_reg  <= sum_reg + SUM_W'(act_rd);
            end
            if (mac_v_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end else begin
            prod_reg <= ma * mb;
        end
        case (state_reg)
            ST_MEAN: begin
                // Own state arrives from the read issued in ST_RDI, the state before.
                r_reg    <= n_rd.pot;
                x_reg    <= n_rd.adapt;
                sold_reg <= n_rd.act;
            end
            ST_NZ:    inh_reg <= 48'(psh);
            ST_FIELD: h_reg <= sat32(64'(acc_s) - 64'(inh_reg) - 64'(psh)
                                     + 64'(back_reg) + 64'(ext_reg));
            ST_POTW:  r_reg <= sat32(64'(r_reg) + 64'(psh));
            ST_ADAPT: x_reg <= sat32(64'(x_reg) + 64'(psh));
            ST_SIG:   s_reg <= sigmoid(psh);
            default: ;
        endcase
        if (wb_go) begin
            m_neuron_reg <= i_reg;
            m_act_reg    <= s_reg;
            m_field_reg  <= h_reg;
            m_pot_reg    <= r_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_updated_neuron = m_neuron_reg;
    assign m_activity       = m_act_reg;
    assign m_input_field    = m_field_reg;
    assign m_potential      = m_pot_reg;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the rate neuron state update core: weight loads, neuron updates
// and register writes, checked beat by beat against a predictor of the update arithmetic.
// Depends on rnsu_pkg and rate_neuron_state_update_core.
`timescale 1ns / 100ps

module testbench;
    import rnsu_pkg::*;

    localparam int N = 64;
    localparam int LIVE = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [5:0]         neuron;
        logic [16:0]        activity;
        logic signed [31:0] field;
        logic signed [31:0] potential;
    } update_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = 1'b0;
    logic [5:0]         s_neuron = '0;
    logic [5:0]         s_source = '0;
    logic signed [31:0] s_weight_value = '0;
    logic signed [31:0] s_ext_field = '0;
    logic signed [31:0] s_back_field = '0;
    logic [15:0]        s_noise_sample = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_updated_neuron;
    logic [16:0]        m_activity;
    logic signed [31:0] m_input_field;
    logic signed [31:0] m_potential;
    logic               cfg_wen = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;

    rate_neuron_state_update_core i_dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_mode, .s_neuron, .s_source, .s_weight_value,
        .s_ext_field, .s_back_field, .s_noise_sample,
        .m_valid, .m_ready, .m_updated_neuron, .m_activity, .m_input_field, .m_potential,
        .cfg_wen, .cfg_index, .cfg_wdata
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor copy of the block state and registers.
    logic signed [31:0] weights [N*N];
    logic [16:0]        act_mem [N];
    logic signed [31:0] pot_mem [N];
    logic signed [31:0] adapt_mem [N];
    logic [30:0]        kappa, eps, inv_temp;
    logic [16:0]        dt_tau, dt_tau_adapt, inv_active;
    logic signed [31:0] thresh;

    // Rows whose weights are all loaded; updates only ever target these neurons.
    int live_rows [LIVE] = '{0, 1, 5, 42, 63, 10, 21, 33};

    update_beat_t expected_updates [$];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  hold_results = 1'b0;

    function automatic longint floor_shift16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [16:0] activity_curve(longint z);
        longint a, y;
        a = (z < 0) ? -z : z;
        if (a >= 327680) y = 65536;
        else if (a >= 155648) y = (a >>> 5) + 55296;
        else if (a >= 65536) y = (a >>> 3) + 40960;
        else y = (a >>> 2) + 32768;
        return 17'((z < 0) ? 65536 - y : y);
    endfunction

    task automatic reset_predictor();
        for (int k = 0; k < N; k++) begin
            act_mem[k] = '0;
            pot_mem[k] = '0;
            adapt_mem[k] = '0;
        end
        kappa = '0;
        eps = '0;
        dt_tau = 17'd6554;
        dt_tau_adapt = 17'd655;
        inv_temp = 31'd65536;
        thresh = '0;
        inv_active = 17'd1024;
    endtask

    // Works out one update of neuron idx and commits the new state.
    task automatic predict_update(int idx, longint ext, longint back, longint noise);
        longint acc, total, mean, msq, inh, nz, h, r, x, z;
        update_beat_t beat;
        acc = 0;
        total = 0;
        for (int j = 0; j < N; j++) begin
            acc += longint'(weights[idx*N+j]) * longint'(act_mem[j]);
            total += longint'(act_mem[j]);
        end
        acc = floor_shift16(acc);
        mean = floor_shift16(total * longint'(inv_active));
        msq = clamp32(floor_shift16(mean * mean));
        inh = floor_shift16(longint'(kappa) * msq);
        nz = floor_shift16(longint'(eps) * (2 * noise - 65536));
        h = clamp32(acc - inh - nz + back + ext);
        r = pot_mem[idx];
        x = adapt_mem[idx];
        r = clamp32(r + floor_shift16(longint'(dt_tau) * (h - r - x)));
        x = clamp32(x + floor_shift16(longint'(dt_tau_adapt) * (longint'(act_mem[idx]) - x)));
        z = floor_shift16(longint'(inv_temp) * (r - longint'(thresh)));
        beat.neuron = 6'(idx);
        beat.activity = activity_curve(z);
        beat.field = 32'(h);
        beat.potential = 32'(r);
        pot_mem[idx] = 32'(r);
        adapt_mem[idx] = 32'(x);
        act_mem[idx] = beat.activity;
        expected_updates.push_back(beat);
    endtask

    // Sends one beat after a random gap and updates the prediction on acceptance.
    // Valid stays high after the beat so that a zero gap gives back-to-back beats.
    task automatic send_beat(bit mode, int idx, int src, logic [31:0] wv,
                             logic [31:0] ext, logic [31:0] back, logic [15:0] noise);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_neuron <= 6'(idx);
        s_source <= 6'(src);
        s_weight_value <= wv;
        s_ext_field <= ext;
        s_back_field <= back;
        s_noise_sample <= noise;
        do @(posedge aclk); while (!s_ready);
        if (mode == 1'b0) begin
            weights[idx*N+src] = wv;
        end else begin
            predict_update(idx, longint'($signed(ext)), longint'($signed(back)), longint'(noise));
        end
        @(negedge aclk);
    endtask

    // Drops valid once the sender has nothing more to offer for a while.
    task automatic release_input();
        s_valid <= 1'b0;
    endtask

    // Register writes happen only once every result is back and the block has gone quiet.
    task automatic write_register(cfg_idx_t idx, logic [31:0] value);
        release_input();
        wait (expected_updates.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_INHIBITION_GAIN:   kappa = value[30:0];
            REG_NOISE_GAIN:        eps = value[30:0];
            REG_STEP_OVER_TAU:     dt_tau = value[16:0];
            REG_STEP_OVER_TAU_ADP: dt_tau_adapt = value[16:0];
            REG_INVERSE_TEMP:      inv_temp = value[30:0];
            REG_THRESHOLD:         thresh = value;
            REG_INV_ACTIVE_COUNT:  inv_active = value[16:0];
            default: begin
            end
        endcase
    endtask

    function automatic logic [31:0] random_q16();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 262144)) - 131072);
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1310720)) - 655360);
        endcase
    endfunction

    // Loads every weight of the live rows so that no update reads an unwritten entry.
    // The first five rows get alternating extreme weights, the rest random ones.
    task automatic load_live_weights();
        for (int n = 0; n < LIVE; n++) begin
            for (int j = 0; j < N; j++) begin
                send_beat(1'b0, live_rows[n], j,
                          (n < 5) ? (((live_rows[n] + j) % 2 != 0) ? 32'h7FFFFFFF
                                                                   : 32'h80000000)
                                  : random_q16(),
                          $urandom(), $urandom(), 16'($urandom()));
            end
        end
    endtask

    task automatic random_update(int idx);
        send_beat(1'b1, idx, $urandom_range(0, 63), $urandom(), random_q16(), random_q16(),
                  16'($urandom()));
    endtask

    // Directed beats: field extremes, noise ends, source and neuron ends.
    task automatic test_directed_extremes();
        send_beat(1'b1, 0, 63, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
        send_beat(1'b1, 63, 0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'h0000);
        send_beat(1'b1, 5, 0, 0, 32'h00010000, 32'h0, 16'h8000);
        send_beat(1'b0, 63, 63, 32'h12345678, 0, 0, 0);
        send_beat(1'b1, 63, 63, 32'hFFFFFFFF, 32'h00050000, 32'hFFFB0000, 16'h0001);
        send_beat(1'b1, 1, 42, 32'h55555555, 32'hFFFF0000, 32'h00020000, 16'h7FFF);
        send_beat(1'b1, 63, 21, 32'hAAAAAAAA, 32'h00028000, 32'h0, 16'hAAAA);
        send_beat(1'b1, 42, 63, 32'h0, 32'h0, 32'h0, 16'h5555);
    endtask

    // Walks the sigmoid through every segment and both signs with a sweep of fields.
    task automatic test_sigmoid_segments();
        write_register(REG_STEP_OVER_TAU, 32'd65536);
        write_register(REG_STEP_OVER_TAU_ADP, 32'd0);
        for (int k = -6; k <= 6; k++) begin
            send_beat(1'b1, live_rows[(k + 6) % LIVE], 0, 0, 32'(k * 40000), 0, 16'h8000);
        end
    endtask

    // Random updates under a given register setting.
    task automatic test_random_phase(int beats, bit with_loads);
        for (int n = 0; n < beats; n++) begin
            if (with_loads && $urandom_range(0, 9) == 0) begin
                send_beat(1'b0, $urandom_range(0, 63), $urandom_range(0, 63), random_q16(),
                          $urandom(), $urandom(), 16'($urandom()));
            end else begin
                random_update(live_rows[$urandom_range(0, LIVE - 1)]);
            end
        end
    endtask

    // Holds the result side for a long stretch so the block fills and stalls its input.
    task automatic test_backpressure();
        fork
            begin
                hold_results = 1'b1;
                repeat (600) @(negedge aclk);
                hold_results = 1'b0;
            end
            begin
                test_random_phase(10, 1'b0);
                release_input();
            end
        join
    endtask

    task automatic test_register_sweep();
        write_register(REG_INHIBITION_GAIN, 32'h7FFFFFFF);
        write_register(REG_NOISE_GAIN, 32'h7FFFFFFF);
        write_register(REG_STEP_OVER_TAU, 32'd65536);
        write_register(REG_STEP_OVER_TAU_ADP, 32'd65536);
        write_register(REG_INVERSE_TEMP, 32'h7FFFFFFF);
        write_register(REG_THRESHOLD, 32'h80000000);
        write_register(REG_INV_ACTIVE_COUNT, 32'd65536);
        test_random_phase(60, 1'b1);
        write_register(REG_THRESHOLD, 32'h7FFFFFFF);
        write_register(REG_INVERSE_TEMP, 32'd0);
        write_register(REG_INV_ACTIVE_COUNT, 32'd0);
        write_register(REG_STEP_OVER_TAU, 32'd0);
        write_register(REG_STEP_OVER_TAU_ADP, 32'd0);
        test_random_phase(40, 1'b1);
        for (int p = 0; p < 4; p++) begin
            write_register(REG_INHIBITION_GAIN, $urandom_range(0, 1 << 18));
            write_register(REG_NOISE_GAIN, $urandom_range(0, 1 << 17));
            write_register(REG_STEP_OVER_TAU, $urandom_range(0, 65536));
            write_register(REG_STEP_OVER_TAU_ADP, $urandom_range(0, 65536));
            write_register(REG_INVERSE_TEMP, $urandom_range(0, 1 << 19));
            write_register(REG_THRESHOLD, 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
            write_register(REG_INV_ACTIVE_COUNT, $urandom_range(0, 65536));
            test_random_phase(60, 1'b1);
        end
    endtask

    // Result side: after each accepted beat, a random number of cycles with ready low.
    initial begin
        int gap_left;
        gap_left = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) gap_left = $urandom_range(0, 8);
            @(negedge aclk);
            if (hold_results || gap_left > 0) begin
                m_ready <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Field-by-field check of each result beat against the oldest prediction.
    always @(posedge aclk) begin
        update_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_updates.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat for neuron %0d", m_updated_neuron);
            end else begin
                want = expected_updates.pop_front();
                if (m_updated_neuron !== want.neuron || m_activity !== want.activity ||
                    m_input_field !== want.field || m_potential !== want.potential) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp n=%0d s=%0d h=%0d r=%0d got n=%0d s=%0d h=%0d r=%0d",
                                 want.neuron, want.activity, want.field, want.potential,
                                 m_updated_neuron, m_activity, m_input_field, m_potential);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        reset_predictor();
        for (int k = 0; k < N*N; k++) begin
            weights[k] = '0;
        end
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        load_live_weights();
        test_directed_extremes();
        test_sigmoid_segments();
        test_backpressure();
        test_register_sweep();
        test_random_phase(60, 1'b1);
        release_input();
        wait (expected_updates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_updates.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/rnsu_pkg.sv
hdl/rnsu_ram.sv
hdl/rnsu_cfg.sv
hdl/rate_neuron_state_update_core.sv
dv/testbench.sv
